FILE: rtl/bqf_pkg.sv
// Shared widths, types and register indexes for the biquad IIR filter.
// No dependencies; every other file in rtl/ imports this package.
package bqf_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 24;
  localparam int FRAC_W    = 20;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  // five products plus the rounding term never need more than three extra bits
  localparam int ACC_W     = PROD_W + 3;
  localparam int SHIFT_W   = ACC_W - FRAC_W;
  localparam int NUM_COEF  = 5;
  localparam int CFG_IDX_W = $clog2(NUM_COEF);

  localparam logic [ACC_W-1:0] ROUND_C = ACC_W'(1) << (FRAC_W - 1);

  // coefficient register indexes
  localparam logic [CFG_IDX_W-1:0] IDX_B0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] IDX_B1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] IDX_B2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] IDX_A1 = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] IDX_A2 = CFG_IDX_W'(4);

  // reset values: identity filter (b0 = 1.0)
  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << FRAC_W;

  typedef struct packed {
    logic                       restart;
    logic signed [SAMPLE_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_set_t;

endpackage

FILE: rtl/biquad_iir_filter_top.sv
// Biquad IIR filter, direct form I. One sample is worked on at a time, as set by the
// single shared 24x16 multiplier stepping through five products plus one accumulate
// and one finish step; the next sample is taken from the queue in the finish step.
// While a result waits on out_ready, a two-entry input queue takes samples until it is full.
// Synchronous active-low reset: coefficients to the identity filter, history zeroed.
// Depends on bqf_pkg, bqf_front, bqf_back.
module biquad_iir_filter_top
  import bqf_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  // input sample channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  input  logic                       in_restart,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  output logic                       out_saturated,
  // coefficient write port
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_idx,
  input  logic [COEF_W-1:0]          cfg_data
);

  coef_set_t coef_r;
  logic      q_valid;
  item_t     q_item;
  logic      q_pop;

  // Coefficient registers, Q3.20. Writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.b0 <= COEF_ONE;
      coef_r.b1 <= '0;
      coef_r.b2 <= '0;
      coef_r.a1 <= '0;
      coef_r.a2 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        IDX_B0:  coef_r.b0 <= cfg_data;
        IDX_B1:  coef_r.b1 <= cfg_data;
        IDX_B2:  coef_r.b2 <= cfg_data;
        IDX_A1:  coef_r.a1 <= cfg_data;
        IDX_A2:  coef_r.a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: accepts sample transfers into the queue.
  bqf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample_in (in_sample_in),
    .in_restart   (in_restart),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  // Back: multiply-accumulate sequencer, history and output register.
  bqf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .coef           (coef_r),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_saturated  (out_saturated)
  );

endmodule

FILE: rtl/bqf_front.sv
// Input side of the biquad filter: takes sample transfers into a two-entry queue.
// Depends on bqf_pkg.
module bqf_front
  import bqf_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  input  logic                       in_restart,
  output logic                       q_valid,
  output item_t                      q_item,
  input  logic                       q_pop
);

  item_t      q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{restart: in_restart, sample: in_sample_in};
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> count_r != 2'd0)
    else $error("queue popped while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("queue count out of range");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> count_r == $past(count_r) + 2'd1)
    else $error("queue count lost a push");

endmodule

FILE: rtl/bqf_back.sv
// Back end of the biquad filter: shared multiplier, accumulator, round/saturate,
// sample history and output register. Depends on bqf_pkg.
module bqf_back
  import bqf_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  coef_set_t                  coef,
  input  logic                       q_valid,
  input  item_t                      q_item,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  output logic                       out_saturated
);

  // sequencer steps: five multiplies, last accumulate, finish
  localparam logic [2:0] STEP_B0   = 3'd0;
  localparam logic [2:0] STEP_B1   = 3'd1;
  localparam logic [2:0] STEP_B2   = 3'd2;
  localparam logic [2:0] STEP_A2   = 3'd3;
  localparam logic [2:0] STEP_A1   = 3'd4;
  localparam logic [2:0] STEP_LAST = 3'd5;
  localparam logic [2:0] STEP_FIN  = 3'd6;

  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  logic                       busy_r;
  logic [2:0]                 step_r;
  logic signed [SAMPLE_W-1:0] x_r, x1_r, x2_r, y1_r, y2_r;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_sat_r;

  logic signed [COEF_W-1:0]   op_c;
  logic signed [SAMPLE_W-1:0] op_s;
  logic signed [ACC_W-1:0]    prod_ext;
  logic [SHIFT_W-1:0]         shifted;
  logic                       sat;
  logic signed [SAMPLE_W-1:0] y_nxt;
  logic                       out_free, fin, issue;

  assign out_free = !out_valid_r || out_ready;
  assign fin      = busy_r && (step_r == STEP_FIN) && out_free;
  assign q_pop    = q_valid && (!busy_r || fin);
  assign issue    = busy_r && (step_r <= STEP_A1);

  // operand select; feedback terms last so y1 is used as late as possible
  always_comb begin
    case (step_r)
      STEP_B0: begin op_c = coef.b0; op_s = x_r;  end
      STEP_B1: begin op_c = coef.b1; op_s = x1_r; end
      STEP_B2: begin op_c = coef.b2; op_s = x2_r; end
      STEP_A2: begin op_c = coef.a2; op_s = y2_r; end
      STEP_A1: begin op_c = coef.a1; op_s = y1_r; end
      default: begin op_c = coef.b0; op_s = x_r;  end
    endcase
    prod_nxt = op_c * op_s;
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_comb begin
    acc_nxt = acc_r;
    case (step_r) inside
      STEP_B1:              acc_nxt = ROUND_C + prod_ext;
      STEP_B2, STEP_A2:     acc_nxt = acc_r + prod_ext;
      STEP_A1, STEP_LAST:   acc_nxt = acc_r - prod_ext;
      default:              acc_nxt = acc_r;
    endcase
  end

  // round already folded in; shift and clip
  assign shifted = acc_r[ACC_W-1:FRAC_W];
  assign sat     = !((&shifted[SHIFT_W-1:SAMPLE_W-1]) || !(|shifted[SHIFT_W-1:SAMPLE_W-1]));
  assign y_nxt   = sat ? (shifted[SHIFT_W-1] ? SAT_MIN : SAT_MAX)
                       : $signed(shifted[SAMPLE_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= STEP_B0;
      out_valid_r <= 1'b0;
      x1_r        <= '0;
      x2_r        <= '0;
      y1_r        <= '0;
      y2_r        <= '0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (busy_r && step_r != STEP_FIN) begin
        step_r <= step_r + 3'd1;
      end
      if (fin) begin
        busy_r      <= 1'b0;
        out_valid_r <= 1'b1;
        x2_r        <= x1_r;
        x1_r        <= x_r;
        y2_r        <= y1_r;
        y1_r        <= y_nxt;
      end
      if (q_pop) begin
        busy_r <= 1'b1;
        step_r <= STEP_B0;
        if (q_item.restart) begin
          x1_r <= '0;
          x2_r <= '0;
          y1_r <= '0;
          y2_r <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      x_r <= q_item.sample;
    end
    if (issue) begin
      prod_r <= prod_nxt;
    end
    if (busy_r) begin
      acc_r <= acc_nxt;
    end
    if (fin) begin
      out_sample_r <= y_nxt;
      out_sat_r    <= sat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_saturated  = out_sat_r;

  a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!busy_r || step_r == STEP_FIN))
    else $error("item taken while sequencer busy");
  a_fin_sets_out: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> out_valid_r)
    else $error("finished result not registered");
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> step_r <= STEP_FIN)
    else $error("sequencer step out of range");
  a_fin_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    fin |-> (!out_valid_r || out_ready))
    else $error("result overwritten before transfer");

endmodule

FILE: bench/tb_biquad_iir_filter_top.sv
`timescale 1ns / 1ps
// Self-checking bench for biquad_iir_filter_top: directed and random samples, checked
// against a fixed-point direct form I predictor. Depends on bqf_pkg and the rtl/ sources.

import bqf_pkg::*;

typedef struct {
  logic signed [SAMPLE_W-1:0] sample;
  logic                       sat;
} filt_out_t;

// Predicts each filtered sample and holds the ones still owed by the block.
class biquad_scoreboard;
  logic signed [COEF_W-1:0]   coef [NUM_COEF];
  logic signed [SAMPLE_W-1:0] x1, x2, y1, y2;
  filt_out_t                  expected_q[$];
  int                         errors;

  function new();
    coef[IDX_B0] = COEF_ONE;
    coef[IDX_B1] = '0;
    coef[IDX_B2] = '0;
    coef[IDX_A1] = '0;
    coef[IDX_A2] = '0;
    x1 = '0;
    x2 = '0;
    y1 = '0;
    y2 = '0;
    errors = 0;
  endfunction

  // indexes past the last coefficient are dropped, as in the block
  function void write_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
    if (idx < NUM_COEF) coef[idx] = data;
  endfunction

  function void note_input(logic signed [SAMPLE_W-1:0] x, logic restart);
    longint    acc;
    longint    q;
    longint    hi;
    longint    lo;
    filt_out_t r;
    hi = (longint'(1) << (SAMPLE_W - 1)) - 1;
    lo = -hi - 1;
    if (restart) begin
      x1 = '0;
      x2 = '0;
      y1 = '0;
      y2 = '0;
    end
    acc = longint'(coef[IDX_B0]) * longint'(x)
        + longint'(coef[IDX_B1]) * longint'(x1)
        + longint'(coef[IDX_B2]) * longint'(x2)
        - longint'(coef[IDX_A1]) * longint'(y1)
        - longint'(coef[IDX_A2]) * longint'(y2);
    // half LSB, then floor shift: ties go toward plus infinity
    acc += longint'(1) << (FRAC_W - 1);
    q = acc >>> FRAC_W;
    r.sat = 1'b1;
    if (q > hi) begin
      r.sample = hi[SAMPLE_W-1:0];
    end else if (q < lo) begin
      r.sample = lo[SAMPLE_W-1:0];
    end else begin
      r.sample = q[SAMPLE_W-1:0];
      r.sat = 1'b0;
    end
    x2 = x1;
    x1 = x;
    y2 = y1;
    y1 = r.sample;
    expected_q.push_back(r);
  endfunction

  function void check_result(logic signed [SAMPLE_W-1:0] y, logic sat);
    filt_out_t e;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result: expected none, got sample %0d sat %0b",
               $time, y, sat);
      return;
    end
    e = expected_q.pop_front();
    if (y !== e.sample) begin
      errors++;
      $display("%0t: sample_out mismatch: expected %0d, got %0d", $time, e.sample, y);
    end
    if (sat !== e.sat) begin
      errors++;
      $display("%0t: saturated mismatch: expected %0b, got %0b", $time, e.sat, sat);
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_biquad_iir_filter_top;

  // no-transfer cycles before the run is declared hung; the long receiver
  // hold-off and the longest sender gap both fit well inside it
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASES         = 14;
  localparam int PHASE_ITEMS    = 125;
  // extra cycles after the last result
  localparam int TAIL_CYCLES    = 20;

  localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  typedef enum {SET_SMOOTH, SET_FEEDFWD, SET_FULL, SET_MAX, SET_MIN, SET_ZERO} coef_kind_e;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample_in;
  logic                       in_restart;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic                       out_saturated;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_idx;
  logic [COEF_W-1:0]          cfg_data;

  // quiet: no idling on either side for the current phase
  // hold_req / hold_taken: one long receiver hold-off, requested by the stimulus
  bit quiet;
  bit hold_req;
  bit hold_taken;

  biquad_scoreboard sb = new();

  biquad_iir_filter_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_saturated  (out_saturated),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_data       (cfg_data)
  );

  always #6 clk = ~clk;

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // Samples: extremes, values near zero, and the full range.
  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return 16'sh7fff;
          1:       return 16'sh8000;
          2:       return 16'sh0000;
          3:       return 16'shffff;
          default: return 16'sh0001;
        endcase
      end
      1, 2, 3: return SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef(int span);
    return COEF_W'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic coef_set_t make_coefs(coef_kind_e kind);
    coef_set_t c;
    case (kind)
      SET_SMOOTH: begin
        // audio-like: feedforward within +-0.5, a1 within +-2, a2 within +-1
        c.b0 = rand_coef(1 << (FRAC_W - 1));
        c.b1 = rand_coef(1 << (FRAC_W - 1));
        c.b2 = rand_coef(1 << (FRAC_W - 1));
        c.a1 = rand_coef(1 << (FRAC_W + 1));
        c.a2 = rand_coef((1 << FRAC_W) - 1);
      end
      SET_FEEDFWD: begin
        c.b0 = COEF_W'($urandom);
        c.b1 = COEF_W'($urandom);
        c.b2 = COEF_W'($urandom);
        c.a1 = '0;
        c.a2 = '0;
      end
      SET_FULL: begin
        c.b0 = COEF_W'($urandom);
        c.b1 = COEF_W'($urandom);
        c.b2 = COEF_W'($urandom);
        c.a1 = COEF_W'($urandom);
        c.a2 = COEF_W'($urandom);
      end
      SET_MAX: c = '{b0: COEF_MAX, b1: COEF_MAX, b2: COEF_MAX, a1: COEF_MAX, a2: COEF_MAX};
      SET_MIN: c = '{b0: COEF_MIN, b1: COEF_MIN, b2: COEF_MIN, a1: COEF_MIN, a2: COEF_MIN};
      default: c = '{b0: '0, b1: '0, b2: '0, a1: '0, a2: '0};
    endcase
    return c;
  endfunction

  // One register write; the block must be idle, so the predictor takes it at once.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    sb.write_coef(idx, data);
  endtask

  // All five coefficients, optionally followed by a write to an unused index
  // that must leave them untouched.
  task automatic apply_coefs(coef_set_t c, bit junk);
    write_reg(IDX_B0, c.b0);
    write_reg(IDX_B1, c.b1);
    write_reg(IDX_B2, c.b2);
    write_reg(IDX_A1, c.a1);
    write_reg(IDX_A2, c.a2);
    if (junk)
      write_reg(CFG_IDX_W'(NUM_COEF + $urandom_range(0, (1 << CFG_IDX_W) - 1 - NUM_COEF)),
                COEF_W'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one sample, after an optional gap, and return once it has transferred.
  // valid stays high straight into the next sample when there is no gap.
  task automatic send_sample(logic signed [SAMPLE_W-1:0] s, logic r);
    int gap;
    gap = quiet ? 0 : idle_len();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_sample_in <= s;
    in_restart   <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, one long hold-off on request, none in quiet phases.
  initial begin
    int stall;
    stall = 0;
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        // long hold-off: the input queue fills and in_ready must drop
        hold_taken = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) stall = idle_len();
      end
    end
  end

  // Transfers are taken at the rising edge; results first, they belong to older samples.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_sample_out, out_saturated);
      if (in_valid && in_ready) sb.note_input(in_sample_in, in_restart);
    end
  end

  // Watchdog: too long without any transfer on either channel means a hang.
  initial begin
    int idle_cnt;
    idle_cnt = 0;
    while (idle_cnt < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cnt = 0;
      else idle_cnt++;
    end
    $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    coef_kind_e kind;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_sample_in <= '0;
    in_restart   <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= '0;
    cfg_data     <= '0;
    quiet        = 1'b0;
    hold_req     = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset coefficients form the identity filter: output equals input.
    send_sample(16'sh0000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0001, 1'b0);
    send_sample(16'shffff, 1'b0);
    send_sample(16'sh5555, 1'b1);
    send_sample(16'shaaaa, 1'b0);
    drain();

    // b0 = 0.5: odd inputs land exactly on half an LSB and must round up.
    // The trailing write to an unused index must not disturb b0.
    apply_coefs('{b0: COEF_ONE >> 1, b1: '0, b2: '0, a1: '0, a2: '0}, 1'b1);
    send_sample(16'sh0001, 1'b0);
    send_sample(16'shffff, 1'b0);
    send_sample(16'sh0003, 1'b0);
    send_sample(16'shfffd, 1'b0);
    drain();

    // Extreme coefficients of both signs: clipping at both rails, history
    // cleared by restart in the middle of a run.
    apply_coefs('{b0: COEF_MAX, b1: COEF_MIN, b2: COEF_MAX, a1: COEF_MIN, a2: COEF_MAX}, 1'b1);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh0000, 1'b1);
    drain();

    // Random phases, each with a new coefficient set; samples mostly run on
    // without restart so the feedback path builds up history.
    for (int p = 0; p < PHASES; p++) begin
      kind = coef_kind_e'(p % 6);
      apply_coefs(make_coefs(kind), 1'($urandom_range(0, 1)));
      quiet = (p % 4 == 3);
      if (p == 2) hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_sample(rand_sample(), $urandom_range(0, 31) == 0);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: %0d results never arrived", $time, sb.pending());
    end
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/bqf_pkg.sv
rtl/bqf_front.sv
rtl/bqf_back.sv
rtl/biquad_iir_filter_top.sv
bench/tb_biquad_iir_filter_top.sv
